// ===== hw/rtl/ypoa_pkg.sv =====
// ----------------------------------------------------------------------------
// Yaw/pitch offset anchor package
// Shared constants, types and the rounding multiply used by the anchor pipeline.
// ----------------------------------------------------------------------------
package ypoa_pkg;

    // Field widths fixed by the interface.
    localparam int OFF_BITS = 22;
    localparam int POS_BITS = 32;
    localparam int QUAT_BITS = 16;
    localparam int CFG_IDX_BITS = 2;

    // Unsigned Q30 values from 0 to one inclusive need 31 bits.
    localparam int Q_W = 31;

    localparam logic [Q_W-1:0] Q30_ONE = 31'h4000_0000;
    localparam logic [Q_W-1:0] Q30_HALF = 31'h2000_0000;

    // Quarter-wave sine polynomial coefficients, Q30.
    localparam logic [Q_W-1:0] POLY_A = 31'd1686629713;
    localparam logic [Q_W-1:0] POLY_B = 31'd688904866;
    localparam logic [Q_W-1:0] POLY_C = 31'd76016977;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_OFF_RIGHT = 2'd0,
        CFG_OFF_BELOW = 2'd1,
        CFG_OFF_FWD   = 2'd2
    } t_cfg_idx;

    // Side data that travels down the pipeline next to the trig values.
    typedef struct packed {
        logic signed [POS_BITS-1:0]  eye_x;
        logic signed [POS_BITS-1:0]  eye_y;
        logic signed [POS_BITS-1:0]  eye_z;
        logic [3:0][1:0]             quad;
        logic signed [QUAT_BITS-1:0] quat_w;
        logic signed [QUAT_BITS-1:0] quat_x;
        logic signed [QUAT_BITS-1:0] quat_y;
        logic signed [QUAT_BITS-1:0] quat_z;
    } t_carry;

    // Product a*b scaled down by 2^sh, rounded half away from zero.
    function automatic logic signed [31:0] mul_round(
        input logic signed [31:0] a,
        input logic signed [31:0] b,
        input int unsigned        sh
    );
        logic [31:0] ma;
        logic [31:0] mb;
        logic [63:0] m;
        logic [31:0] q;
        ma = a[31] ? 32'(-a) : 32'(a);
        mb = b[31] ? 32'(-b) : 32'(b);
        m = 64'(ma) * 64'(mb) + (64'd1 << (sh - 1));
        m = m >> sh;
        q = m[31:0];
        return (a[31] ^ b[31]) ? -$signed(q) : $signed(q);
    endfunction

endpackage

// ===== hw/rtl/ypoa_sin_quarter.sv =====
// ----------------------------------------------------------------------------
// Quarter-wave sine pipeline
// Four-stage Horner evaluation of the odd sine polynomial on [0, 1] in Q30.
// ----------------------------------------------------------------------------
module ypoa_sin_quarter (
    input  logic                    i_clk,
    input  logic [3:0]              i_en,
    input  logic [ypoa_pkg::Q_W-1:0] i_t,
    output logic [ypoa_pkg::Q_W-1:0] o_s
);
    import ypoa_pkg::*;

    logic [Q_W-1:0] r_t_a, r_t2_a;
    logic [Q_W-1:0] r_t_b, r_t2_b, r_inner;
    logic [Q_W-1:0] r_t_c, r_mid;
    logic [Q_W-1:0] r_s;

    logic [61:0] p1, p2, p3, p4;
    logic [Q_W-1:0] n_t2, n_inner, n_mid, n_s;

    // Each stage holds one product of two Q30 values, rounded back to Q30.
    always_comb begin
        p1 = 62'(i_t) * 62'(i_t) + 62'(Q30_HALF);
        n_t2 = p1[60:30];
        p2 = 62'(POLY_C) * 62'(r_t2_a) + 62'(Q30_HALF);
        n_inner = POLY_B - p2[60:30];
        p3 = 62'(r_t2_b) * 62'(r_inner) + 62'(Q30_HALF);
        n_mid = POLY_A - p3[60:30];
        p4 = 62'(r_t_c) * 62'(r_mid) + 62'(Q30_HALF);
        n_s = (p4[61:30] > 32'(Q30_ONE)) ? Q30_ONE : p4[60:30];
    end

    // Pipeline registers, loaded when the owning stage moves.
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_t_a  <= i_t;
            r_t2_a <= n_t2;
        end
        if (i_en[1]) begin
            r_t_b   <= r_t_a;
            r_t2_b  <= r_t2_a;
            r_inner <= n_inner;
        end
        if (i_en[2]) begin
            r_t_c <= r_t_b;
            r_mid <= n_mid;
        end
        if (i_en[3]) begin
            r_s <= n_s;
        end
    end

    assign o_s = r_s;

endmodule

// ===== hw/rtl/yaw_pitch_offset_anchor_unit.sv =====
// ----------------------------------------------------------------------------
// Yaw/pitch offset anchor unit
// Grip point and view quaternion from an eye pose and three grip offsets.
// ----------------------------------------------------------------------------
// The unit takes one eye pose word per clock and returns one result word per
// clock when the output side does not stall. The pipeline has nine stages:
// one input stage, four stages of quarter-wave sine polynomial, a quadrant
// fold, the axis and quaternion products, the offset products, and the
// saturating sum. Every stage has its own valid bit, so bubbles close up and
// a stall on the output stops only the stages behind full ones. Offsets reset
// to zero and are written through the configuration port; the user must write
// them only while the unit is idle, which the unit itself does not enforce.
module yaw_pitch_offset_anchor_unit #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_rst_n,
    // Configuration port.
    input  logic                                     i_cfg_wr_en,
    input  logic [ypoa_pkg::CFG_IDX_BITS-1:0]        i_cfg_idx,
    input  logic [ypoa_pkg::OFF_BITS-1:0]            i_cfg_data,
    // Pose input channel.
    input  logic                                     i_valid,
    output logic                                     o_ready,
    input  logic signed [ANGLE_BITS-1:0]             i_yaw_angle,
    input  logic signed [ANGLE_BITS-1:0]             i_pitch_angle,
    input  logic signed [ypoa_pkg::POS_BITS-1:0]     i_eye_x,
    input  logic signed [ypoa_pkg::POS_BITS-1:0]     i_eye_y,
    input  logic signed [ypoa_pkg::POS_BITS-1:0]     i_eye_z,
    // Result output channel.
    output logic                                     o_valid,
    input  logic                                     i_ready,
    output logic signed [ypoa_pkg::POS_BITS-1:0]     o_grip_x,
    output logic signed [ypoa_pkg::POS_BITS-1:0]     o_grip_y,
    output logic signed [ypoa_pkg::POS_BITS-1:0]     o_grip_z,
    output logic signed [ypoa_pkg::QUAT_BITS-1:0]    o_quat_w,
    output logic signed [ypoa_pkg::QUAT_BITS-1:0]    o_quat_x,
    output logic signed [ypoa_pkg::QUAT_BITS-1:0]    o_quat_y,
    output logic signed [ypoa_pkg::QUAT_BITS-1:0]    o_quat_z
);
    import ypoa_pkg::*;

    localparam int STAGES = 9;
    localparam int ST_FOLD = 5;
    localparam int ST_AXIS = 6;
    localparam int ST_OFFS = 7;
    localparam int ST_SUM = 8;
    localparam int FULL_PAD = 32 - ANGLE_BITS;
    localparam int HALF_PAD = 31 - ANGLE_BITS;

    // Configuration registers.
    logic signed [OFF_BITS-1:0] r_off_right, r_off_below, r_off_fwd;

    // Valid bits and stage moves.
    logic [STAGES-1:0] r_v;
    logic [STAGES-1:0] n_v;
    logic [STAGES:0]   rdy;

    // Side data and stage-zero angle fractions.
    t_carry r_car [STAGES];
    t_carry n_car_in;
    t_carry n_car_axis;
    logic [Q_W-2:0] r_t [4];

    // Sine pipeline ports: 0..3 sine inputs, 4..7 cosine inputs.
    logic [Q_W-1:0] w_tin [8];
    logic [Q_W-1:0] w_sq [8];

    // Folded trig: 0 yaw, 1 pitch, 2 half yaw, 3 half pitch.
    logic signed [31:0] r_sn [4];
    logic signed [31:0] r_cs [4];
    logic signed [31:0] n_sn [4];
    logic signed [31:0] n_cs [4];

    // Axis stage.
    logic signed [31:0] r_up_x, r_up_z, r_fw_x, r_fw_z;
    logic signed [31:0] r_cy6, r_sy6, r_cp6, r_sp6;

    // Offset product stage.
    logic signed [31:0] r_px, r_pz, r_ux, r_uy, r_uz, r_fx, r_fy, r_fz;

    // Output registers.
    logic signed [POS_BITS-1:0] r_grip_x, r_grip_y, r_grip_z;
    logic signed [34:0] n_sum_x, n_sum_y, n_sum_z;

    // Configuration writes; an index outside the list is dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off_right <= '0;
            r_off_below <= '0;
            r_off_fwd   <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_OFF_RIGHT: r_off_right <= i_cfg_data;
                CFG_OFF_BELOW: r_off_below <= i_cfg_data;
                CFG_OFF_FWD:   r_off_fwd   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A stage moves when it is empty or the stage after it moves.
    always_comb begin
        rdy[STAGES] = i_ready;
        for (int k = STAGES - 1; k >= 0; k--) begin
            rdy[k] = !r_v[k] || rdy[k+1];
        end
        n_v = {r_v[STAGES-2:0], i_valid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            for (int k = 0; k < STAGES; k++) begin
                if (rdy[k]) begin
                    r_v[k] <= n_v[k];
                end
            end
        end
    end

    assign o_ready = rdy[0];
    assign o_valid = r_v[STAGES-1];

    // Side data of an incoming word: eye position and the angle quadrants.
    always_comb begin
        n_car_in = '0;
        n_car_in.eye_x   = i_eye_x;
        n_car_in.eye_y   = i_eye_y;
        n_car_in.eye_z   = i_eye_z;
        n_car_in.quad[0] = i_yaw_angle[ANGLE_BITS-1:ANGLE_BITS-2];
        n_car_in.quad[1] = i_pitch_angle[ANGLE_BITS-1:ANGLE_BITS-2];
        n_car_in.quad[2] = {2{i_yaw_angle[ANGLE_BITS-1]}};
        n_car_in.quad[3] = {2{i_pitch_angle[ANGLE_BITS-1]}};
    end

    // Stage zero: Q30 fraction of each full and half angle.
    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_t[0] <= {i_yaw_angle[ANGLE_BITS-3:0], {FULL_PAD{1'b0}}};
            r_t[1] <= {i_pitch_angle[ANGLE_BITS-3:0], {FULL_PAD{1'b0}}};
            r_t[2] <= {i_yaw_angle[ANGLE_BITS-2:0], {HALF_PAD{1'b0}}};
            r_t[3] <= {i_pitch_angle[ANGLE_BITS-2:0], {HALF_PAD{1'b0}}};
        end
    end

    // Sine of the fraction and of its complement, which gives the cosine.
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            w_tin[j]   = {1'b0, r_t[j]};
            w_tin[j+4] = Q30_ONE - {1'b0, r_t[j]};
        end
    end

    for (genvar g = 0; g < 8; g++) begin : g_sinq
        ypoa_sin_quarter u_sinq (
            .i_clk (i_clk),
            .i_en  (rdy[4:1]),
            .i_t   (w_tin[g]),
            .o_s   (w_sq[g])
        );
    end

    // Quadrant fold into signed sine and cosine.
    always_comb begin
        for (int j = 0; j < 4; j++) begin
            unique case (r_car[4].quad[j])
                2'd0: begin
                    n_sn[j] = $signed(32'(w_sq[j]));
                    n_cs[j] = $signed(32'(w_sq[j+4]));
                end
                2'd1: begin
                    n_sn[j] = $signed(32'(w_sq[j+4]));
                    n_cs[j] = -$signed(32'(w_sq[j]));
                end
                2'd2: begin
                    n_sn[j] = -$signed(32'(w_sq[j]));
                    n_cs[j] = -$signed(32'(w_sq[j+4]));
                end
                default: begin
                    n_sn[j] = -$signed(32'(w_sq[j+4]));
                    n_cs[j] = $signed(32'(w_sq[j]));
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy[ST_FOLD]) begin
            for (int j = 0; j < 4; j++) begin
                r_sn[j] <= n_sn[j];
                r_cs[j] <= n_cs[j];
            end
        end
    end

    // Quaternion from the half angles, joined to the side data here.
    always_comb begin
        n_car_axis = r_car[ST_FOLD];
        n_car_axis.quat_w = QUAT_BITS'(mul_round(r_cs[2], r_cs[3], 46));
        n_car_axis.quat_x = QUAT_BITS'(mul_round(r_cs[2], r_sn[3], 46));
        n_car_axis.quat_y = QUAT_BITS'(-mul_round(r_sn[2], r_cs[3], 46));
        n_car_axis.quat_z = QUAT_BITS'(mul_round(r_sn[2], r_sn[3], 46));
    end

    // Side data shift line.
    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_car[0] <= n_car_in;
        end
        for (int k = 1; k < STAGES; k++) begin
            if (rdy[k]) begin
                r_car[k] <= (k == ST_AXIS) ? n_car_axis : r_car[k-1];
            end
        end
    end

    // View axes from the full angles.
    always_ff @(posedge i_clk) begin
        if (rdy[ST_AXIS]) begin
            r_up_x <= -mul_round(r_sn[0], r_sn[1], 30);
            r_up_z <= mul_round(r_cs[0], r_sn[1], 30);
            r_fw_x <= mul_round(r_sn[0], r_cs[1], 30);
            r_fw_z <= -mul_round(r_cs[0], r_cs[1], 30);
            r_cy6  <= r_cs[0];
            r_sy6  <= r_sn[0];
            r_cp6  <= r_cs[1];
            r_sp6  <= r_sn[1];
        end
    end

    // Offsets scaled along each axis.
    always_ff @(posedge i_clk) begin
        if (rdy[ST_OFFS]) begin
            r_px <= mul_round(r_cy6, 32'(r_off_right), 30);
            r_pz <= mul_round(r_sy6, 32'(r_off_right), 30);
            r_ux <= mul_round(r_up_x, 32'(r_off_below), 30);
            r_uy <= mul_round(r_cp6, 32'(r_off_below), 30);
            r_uz <= mul_round(r_up_z, 32'(r_off_below), 30);
            r_fx <= mul_round(r_fw_x, 32'(r_off_fwd), 30);
            r_fy <= mul_round(r_sp6, 32'(r_off_fwd), 30);
            r_fz <= mul_round(r_fw_z, 32'(r_off_fwd), 30);
        end
    end

    // Exact sum, then saturation to the position range.
    always_comb begin
        n_sum_x = 35'(r_car[ST_OFFS].eye_x) + 35'(r_px) - 35'(r_ux) + 35'(r_fx);
        n_sum_y = 35'(r_car[ST_OFFS].eye_y) - 35'(r_uy) + 35'(r_fy);
        n_sum_z = 35'(r_car[ST_OFFS].eye_z) + 35'(r_pz) - 35'(r_uz) + 35'(r_fz);
    end

    function automatic logic signed [POS_BITS-1:0] sat_pos(input logic signed [34:0] v);
        if (v > 35'sh0_7FFF_FFFF) begin
            return 32'sh7FFF_FFFF;
        end else if (v < -35'sh0_8000_0000) begin
            return -32'sh8000_0000;
        end
        return v[POS_BITS-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (rdy[ST_SUM]) begin
            r_grip_x <= sat_pos(n_sum_x);
            r_grip_y <= sat_pos(n_sum_y);
            r_grip_z <= sat_pos(n_sum_z);
        end
    end

    assign o_grip_x = r_grip_x;
    assign o_grip_y = r_grip_y;
    assign o_grip_z = r_grip_z;
    assign o_quat_w = r_car[ST_SUM].quat_w;
    assign o_quat_x = r_car[ST_SUM].quat_x;
    assign o_quat_y = r_car[ST_SUM].quat_y;
    assign o_quat_z = r_car[ST_SUM].quat_z;

    // A full pipeline with a stalled output takes no new word.
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_v && !i_ready) |-> !o_ready)
        else $error("pose taken while pipeline full and stalled");

    // No result appears in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Quaternion components stay within one.
    a_quat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_quat_w <= 16'sd16384 && o_quat_w >= -16'sd16384 &&
                     o_quat_x <= 16'sd16384 && o_quat_x >= -16'sd16384 &&
                     o_quat_y <= 16'sd16384 && o_quat_y >= -16'sd16384 &&
                     o_quat_z <= 16'sd16384 && o_quat_z >= -16'sd16384))
        else $error("quaternion component out of range");

endmodule
